### rtl/assert_macros.svh
// Assertion helpers shared by the RTL; every user clocks on i_clk and resets on i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds whenever ante holds.
`define SFDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check that cond never holds.
`define SFDC_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### rtl/sfdc_pkg.sv
package sfdc_pkg;

    localparam int FRAME_LEN   = 9;
    localparam int BODY_LEN    = 7;
    localparam int NUM_DIGITS  = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int POS_W       = 4;
    localparam int SCAN_W      = 3;
    localparam int SLOT_W      = 3;

    localparam logic [7:0] HDR_BYTE         = 8'h7E;
    localparam logic [7:0] END_BYTE         = 8'h7F;
    localparam logic [7:0] CMD_SHOW         = 8'h30;
    localparam logic [7:0] CMD_ASK          = 8'h32;
    localparam logic [7:0] CMD_ANSWER       = 8'h31;
    localparam logic [7:0] CHAR_ZERO        = 8'h30;
    localparam logic [7:0] STATION_ID_RESET = 8'd57;

    // Request and result kinds
    localparam logic REQ_BYTE     = 1'b0;
    localparam logic REQ_SCAN     = 1'b1;
    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_DISPLAY = 1'b1;

    // Byte positions within a frame
    localparam logic [POS_W-1:0] POS_HDR      = 4'd0;
    localparam logic [POS_W-1:0] POS_ID       = 4'd1;
    localparam logic [POS_W-1:0] POS_CMD      = 4'd2;
    localparam logic [POS_W-1:0] POS_SENSOR_A = 4'd6;
    localparam logic [POS_W-1:0] POS_SENSOR_B = 4'd7;
    localparam logic [POS_W-1:0] POS_END      = 4'd8;

    // Body slots (frame positions 1..7)
    localparam int SLOT_ID    = 0;
    localparam int SLOT_CMD   = 1;
    localparam int SLOT_DIGIT = 2;

    // Configuration register word indexes
    localparam logic REG_STATION_ID = 1'b0;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic       sensor_a;
        logic       sensor_b;
    } t_in_word;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] tx_byte;
        logic [7:0] segments;
        logic [4:0] digit_enable;
        logic       last;
    } t_out_word;

    // One queued job: a display word, or a reply to expand into a frame
    typedef struct packed {
        logic                  is_scan;
        logic [7:0]            segments;
        logic [NUM_DIGITS-1:0] digit_enable;
        logic [7:0]            id;
        logic                  sensor_a;
        logic                  sensor_b;
    } t_job;

    function automatic logic [7:0] seg_pattern(input logic [7:0] val);
        logic [7:0] pat;
        case (val)
            8'd0:    pat = 8'hfc;
            8'd1:    pat = 8'h60;
            8'd2:    pat = 8'hda;
            8'd3:    pat = 8'hf2;
            8'd4:    pat = 8'h66;
            8'd5:    pat = 8'hb6;
            8'd6:    pat = 8'hbe;
            8'd7:    pat = 8'he0;
            8'd8:    pat = 8'hfe;
            8'd9:    pat = 8'hf6;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

    function automatic logic [7:0] reply_byte(input logic [POS_W-1:0] idx,
                                              input logic [7:0] id,
                                              input logic sa,
                                              input logic sb);
        logic [7:0] b;
        case (idx)
            POS_HDR:      b = HDR_BYTE;
            POS_ID:       b = id;
            POS_CMD:      b = CMD_ANSWER;
            POS_SENSOR_A: b = CHAR_ZERO | {7'd0, sa};
            POS_SENSOR_B: b = CHAR_ZERO | {7'd0, sb};
            POS_END:      b = END_BYTE;
            default:      b = CHAR_ZERO;
        endcase
        return b;
    endfunction

endpackage

### rtl/sfdc_front.sv
module sfdc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sfdc_pkg::t_in_word i_word,
    input  logic             i_full,
    input  logic [7:0]       i_station_id,
    output logic             o_stall,
    output logic             o_push,
    output sfdc_pkg::t_job   o_job
);
    import sfdc_pkg::*;

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [SCAN_W-1:0] r_scan,  n_scan;
    logic [7:0]        r_body  [BODY_LEN];
    logic [7:0]        r_digit [NUM_DIGITS];
    logic [7:0]        n_digit [NUM_DIGITS];
    logic              w_accept;
    logic              w_store;
    logic [SLOT_W-1:0] w_slot;
    logic [SCAN_W-1:0] w_scan_pos;
    logic [7:0]        w_scan_val;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign w_slot   = SLOT_W'(r_pos - POS_ID);

    always_comb begin
        w_scan_pos = (r_scan >= SCAN_W'(NUM_DIGITS)) ? '0 : r_scan;
        w_scan_val = 8'd0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (w_scan_pos == SCAN_W'(k)) begin
                w_scan_val = r_digit[k];
            end
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_scan  = r_scan;
        n_digit = r_digit;
        w_store = 1'b0;
        o_push  = 1'b0;
        o_job   = '0;
        if (w_accept) begin
            if (i_word.req_type == REQ_SCAN) begin
                o_push             = 1'b1;
                o_job.is_scan      = 1'b1;
                o_job.segments     = seg_pattern(w_scan_val);
                o_job.digit_enable = NUM_DIGITS'(1) << w_scan_pos;
                n_scan = (w_scan_pos == SCAN_W'(NUM_DIGITS - 1)) ? '0 : w_scan_pos + 1'b1;
            end else if (r_pos == POS_HDR) begin
                // resync until a header byte shows up
                n_pos = (i_word.rx_byte == HDR_BYTE) ? POS_ID : POS_HDR;
            end else if (r_pos == POS_END) begin
                n_pos = POS_HDR;
                if (i_word.rx_byte == END_BYTE && r_body[SLOT_ID] == i_station_id) begin
                    if (r_body[SLOT_CMD] == CMD_SHOW) begin
                        for (int k = 0; k < NUM_DIGITS; k++) begin
                            n_digit[k] = r_body[SLOT_DIGIT + k] - CHAR_ZERO;
                        end
                    end else if (r_body[SLOT_CMD] == CMD_ASK) begin
                        o_push         = 1'b1;
                        o_job.id       = i_station_id;
                        o_job.sensor_a = i_word.sensor_a;
                        o_job.sensor_b = i_word.sensor_b;
                    end
                end
            end else begin
                w_store = 1'b1;
                n_pos   = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HDR;
            r_scan <= '0;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_digit[k] <= 8'd0;
            end
        end else begin
            r_pos   <= n_pos;
            r_scan  <= n_scan;
            r_digit <= n_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_body[w_slot] <= i_word.rx_byte;
        end
    end

endmodule

### rtl/sfdc_queue.sv
`include "assert_macros.svh"

module sfdc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfdc_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sfdc_pkg::t_job o_head
);
    import sfdc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `SFDC_ASSERT_NEVER(a_count_range, r_count > CNT_W'(QUEUE_DEPTH))
    `SFDC_ASSERT_IMP(a_pop_nonempty, i_pop, r_count != '0)
    `SFDC_ASSERT_IMP(a_push_room, i_push, r_count != CNT_W'(QUEUE_DEPTH))

endmodule

### rtl/sfdc_back.sv
`include "assert_macros.svh"

module sfdc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  sfdc_pkg::t_job      i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output sfdc_pkg::t_out_word o_word
);
    import sfdc_pkg::*;

    logic             r_valid, n_valid;
    t_out_word        r_word,  n_word;
    logic [POS_W-1:0] r_idx,   n_idx;
    logic             w_load;

    assign w_load  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        if (w_load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_word = '0;
                if (i_head.is_scan) begin
                    n_word.out_kind     = KIND_DISPLAY;
                    n_word.segments     = i_head.segments;
                    n_word.digit_enable = i_head.digit_enable;
                    n_word.last         = 1'b1;
                    o_pop               = 1'b1;
                end else begin
                    // walk the reply frame one byte per word
                    n_word.out_kind = KIND_TX;
                    n_word.tx_byte  = reply_byte(r_idx, i_head.id,
                                                 i_head.sensor_a, i_head.sensor_b);
                    n_word.last     = (r_idx == POS_END);
                    o_pop           = (r_idx == POS_END);
                    n_idx           = (r_idx == POS_END) ? POS_HDR : r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= POS_HDR;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    `SFDC_ASSERT_NEVER(a_idx_range, r_idx > POS_END)
    `SFDC_ASSERT_IMP(a_idx_reply_head, r_idx != POS_HDR, !i_empty && !i_head.is_scan)
    `SFDC_ASSERT_IMP(a_display_onehot, r_valid && r_word.out_kind == KIND_DISPLAY,
        $onehot(r_word.digit_enable) && r_word.last)

endmodule

### rtl/serial_frame_display_controller.sv
// Serial frame display controller. Each input word is either a received serial byte or a
// display scan tick. Bytes assemble 9-byte frames (0x7E, id, command, five digit characters,
// 0x7F); a frame with matching id and end byte and command '0' loads the five digits, and
// command '2' queues a 9-word reply carrying the two sensor levels sampled with the frame's
// last byte. Each scan tick yields one display word with the digit's segment pattern and a
// one-hot digit select. Rate: an input word is taken every cycle while the two-entry job
// queue has room; the output register issues one word per cycle while the output is not
// stalled, so a reply holds the output for its nine words, which sets the throughput when
// replies are back to back. An input word passes the job queue, then the output register.
// station_id sits at byte address 0 of the register port and resets to 57.
module serial_frame_display_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input words
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sfdc_pkg::t_in_word  i_in_word,
    // output words
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sfdc_pkg::t_out_word o_out_word,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sfdc_pkg::*;

    logic [7:0] r_station_id;
    logic       w_reg_sel;
    logic       w_push, w_pop, w_full, w_empty;
    t_job       w_push_job, w_head;

    // Register port: single register, word index taken from paddr[2].
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == REG_STATION_ID);
    assign prdata    = w_reg_sel ? {24'd0, r_station_id} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_id <= STATION_ID_RESET;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_station_id <= pwdata[7:0];
        end
    end

    // Front end: frame assembly, digit store, scan position; emits jobs.
    sfdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_word       (i_in_word),
        .i_full       (w_full),
        .i_station_id (r_station_id),
        .o_stall      (o_in_stall),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    // Short job queue decouples the front end from a stalled output.
    sfdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // Back end: expand jobs into output words behind an output register.
    sfdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

### tb/tb_serial_frame_display_controller.sv
`timescale 1ns / 100ps

module tb_serial_frame_display_controller;
    import sfdc_pkg::*;

    // Abort the run after this many cycles; a correct run needs far fewer.
    localparam int CYCLE_LIMIT = 200000;
    // Let the block settle this long once nothing is awaited.
    localparam int SETTLE_CYCLES = 12;
    // Print at most this many mismatch lines; count them all.
    localparam int REPORT_CAP = 100;

    typedef struct {
        t_in_word word;
        bit       drain_first;  // hold this word back until every awaited word is in
    } t_send_entry;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_word    i_in_word  = '0;
    logic        i_out_stall = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic [31:0] prdata;
    logic        pready;

    serial_frame_display_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    // Words waiting to be driven, and display/reply words the block still owes us.
    t_send_entry words_to_send[$];
    t_out_word   awaited_words[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap    = 0;
    int unsigned recv_hold   = 0;
    bit          calm        = 1'b0;  // set to drop all random idling on both sides

    // Predictor state: our own copy of the register, frame buffer, digits and scan.
    logic [7:0] cfg_station_id;
    logic [7:0] rx_frame [0:FRAME_LEN-1];
    logic [3:0] rx_pos;
    logic [7:0] digit_val [0:NUM_DIGITS-1];
    logic [2:0] scan_pos;
    logic [7:0] glyph_rom [0:9] = '{8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66,
                                    8'hb6, 8'hbe, 8'he0, 8'hfe, 8'hf6};

    task automatic report_mismatch(input string msg);
        if (error_count < REPORT_CAP)
            $display("mismatch @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Advance the predictor by one accepted input word; queue the words it owes.
    task automatic predict_outputs(input t_in_word w);
        logic [2:0] pos;
        logic [7:0] val;
        logic [7:0] reply [0:FRAME_LEN-1];
        t_out_word  r;
        if (w.req_type == REQ_SCAN) begin
            pos = scan_pos;
            if (pos >= NUM_DIGITS)
                pos = 3'd0;
            val = digit_val[pos];
            r = '0;
            r.out_kind     = KIND_DISPLAY;
            r.segments     = (val < 8'd10) ? glyph_rom[val] : 8'h00;
            r.digit_enable = 5'b00001 << pos;
            r.last         = 1'b1;
            awaited_words.push_back(r);
            scan_pos = 3'((pos + 3'd1) % NUM_DIGITS);
            return;
        end
        if (rx_pos >= FRAME_LEN)
            rx_pos = 4'd0;
        rx_frame[rx_pos] = w.rx_byte;
        rx_pos = rx_pos + 4'd1;
        // Resync whenever the first stored byte is not a header.
        if (rx_frame[0] != HDR_BYTE)
            rx_pos = 4'd0;
        if (rx_pos != FRAME_LEN)
            return;
        rx_pos = 4'd0;
        if (rx_frame[FRAME_LEN-1] != END_BYTE || rx_frame[1] != cfg_station_id)
            return;
        if (rx_frame[2] == CMD_SHOW) begin
            for (int i = 0; i < NUM_DIGITS; i++)
                digit_val[i] = rx_frame[3+i] - 8'd48;
        end else if (rx_frame[2] == CMD_ASK) begin
            reply[0] = HDR_BYTE;
            reply[1] = cfg_station_id;
            reply[2] = CMD_ANSWER;
            reply[3] = CHAR_ZERO;
            reply[4] = CHAR_ZERO;
            reply[5] = CHAR_ZERO;
            reply[6] = CHAR_ZERO | {7'd0, w.sensor_a};
            reply[7] = CHAR_ZERO | {7'd0, w.sensor_b};
            reply[8] = END_BYTE;
            for (int i = 0; i < FRAME_LEN; i++) begin
                r = '0;
                r.out_kind = KIND_TX;
                r.tx_byte  = reply[i];
                r.last     = (i == FRAME_LEN - 1);
                awaited_words.push_back(r);
            end
        end
        // Any accepted frame, whatever its command, empties the buffer.
        for (int i = 0; i < FRAME_LEN; i++)
            rx_frame[i] = 8'h00;
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (awaited_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", got));
            return;
        end
        want = awaited_words.pop_front();
        if (got.out_kind !== want.out_kind)
            report_mismatch($sformatf("out_kind %h, want %h", got.out_kind, want.out_kind));
        if (got.tx_byte !== want.tx_byte)
            report_mismatch($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
        if (got.segments !== want.segments)
            report_mismatch($sformatf("segments %h, want %h", got.segments, want.segments));
        if (got.digit_enable !== want.digit_enable)
            report_mismatch($sformatf("digit_enable %b, want %b",
                                      got.digit_enable, want.digit_enable));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask

    // Input driver: present the next queued word, hold it while stalled,
    // then idle for a drawn number of cycles before the next one.
    always @(posedge i_clk) begin : drive_words
        t_send_entry nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_outputs(i_in_word);
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap != 0) begin
                    i_in_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end else if (words_to_send.size() != 0 &&
                             !(words_to_send[0].drain_first &&
                               awaited_words.size() != 0)) begin
                    nxt = words_to_send.pop_front();
                    i_in_word  <= nxt.word;
                    i_in_valid <= 1'b1;
                    send_gap   <= calm ? 0 : $urandom_range(0, 3);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check every accepted word, then stall for a drawn
    // number of cycles before taking the next.
    always @(posedge i_clk) begin : watch_words
        int unsigned w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_hold   <= 0;
        end else begin
            w = recv_hold;
            if (o_out_valid && !i_out_stall) begin
                check_word(o_out_word);
                w = calm ? 0 : $urandom_range(0, 3);
            end
            if (w != 0) begin
                i_out_stall <= 1'b1;
                recv_hold   <= w - 1;
            end else begin
                i_out_stall <= 1'b0;
                recv_hold   <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_serial_frame_display_controller: FAIL");
            $finish;
        end
    end

    // Write station_id over the register port, then read it back.
    task automatic reg_write(input logic [7:0] value);
        logic [31:0] data;
        data = $urandom;
        data[7:0] = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_STATION_ID);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        cfg_station_id = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== {24'd0, value})
            report_mismatch($sformatf("station_id reads %h, want %h", prdata, value));
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_word(input t_in_word w, input bit drain);
        t_send_entry e;
        e.word        = w;
        e.drain_first = drain | ($urandom_range(0, 31) == 0);
        words_to_send.push_back(e);
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_in_word w;
        w.req_type = REQ_BYTE;
        w.rx_byte  = b;
        w.sensor_a = 1'($urandom_range(0, 1));
        w.sensor_b = 1'($urandom_range(0, 1));
        push_word(w, 1'b0);
    endtask

    task automatic push_scan(input bit drain);
        t_in_word w;
        w.req_type = REQ_SCAN;
        w.rx_byte  = 8'($urandom_range(0, 255));
        w.sensor_a = 1'($urandom_range(0, 1));
        w.sensor_b = 1'($urandom_range(0, 1));
        push_word(w, drain);
    endtask

    // Queue one frame; with mix set, scan ticks may land between its bytes.
    task automatic push_frame(input logic [7:0] id, input logic [7:0] cmd,
                              input logic [39:0] chars, input logic [7:0] tail,
                              input bit mix);
        logic [7:0] bytes [0:FRAME_LEN-1];
        bytes[0] = HDR_BYTE;
        bytes[1] = id;
        bytes[2] = cmd;
        for (int i = 0; i < NUM_DIGITS; i++)
            bytes[3+i] = chars[39-8*i -: 8];
        bytes[8] = tail;
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (mix && $urandom_range(0, 7) == 0)
                push_scan(1'b0);
            push_byte(bytes[i]);
        end
    endtask

    // Mostly well-formed frames with random content; the rest is scan runs,
    // line noise and frames cut short.
    task automatic queue_random_traffic(input int unsigned n_items);
        int unsigned target;
        int unsigned pick;
        logic [7:0]  id, cmd, tail;
        logic [39:0] chars;
        target = words_to_send.size() + n_items;
        while (words_to_send.size() < target) begin
            pick = $urandom_range(0, 15);
            if (pick <= 9) begin
                id = (pick == 9) ? 8'($urandom_range(0, 255)) : cfg_station_id;
                case ($urandom_range(0, 4))
                    0, 1:    cmd = CMD_SHOW;
                    2, 3:    cmd = CMD_ASK;
                    default: cmd = 8'($urandom_range(0, 255));
                endcase
                for (int i = 0; i < NUM_DIGITS; i++)
                    chars[8*i +: 8] = ($urandom_range(0, 7) == 0) ?
                                      8'($urandom_range(0, 255)) :
                                      8'(CHAR_ZERO + $urandom_range(0, 9));
                tail = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : END_BYTE;
                push_frame(id, cmd, chars, tail, 1'b1);
            end else if (pick == 13) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            end else if (pick == 14) begin
                push_byte(HDR_BYTE);
                repeat ($urandom_range(0, 7)) push_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) push_scan(1'b0);
            end
        end
    endtask

    // Wait until every word is sent and answered, then let the block settle.
    task automatic wait_idle;
        while (words_to_send.size() != 0 || i_in_valid || awaited_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        cfg_station_id = STATION_ID_RESET;
        rx_pos   = 4'd0;
        scan_pos = 3'd0;
        for (int i = 0; i < FRAME_LEN; i++)
            rx_frame[i] = 8'h00;
        for (int i = 0; i < NUM_DIGITS; i++)
            digit_val[i] = 8'h00;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: load digits 0, 9, one past nine, wrap below zero and the
        // top byte, scan all five (the last three blank), then ask for a reply
        // and hold the next tick until the reply is out.
        push_frame(STATION_ID_RESET, CMD_SHOW, {CHAR_ZERO, 8'h39, 8'h3A, 8'h2F, 8'hFF},
                   END_BYTE, 1'b0);
        repeat (NUM_DIGITS) push_scan(1'b0);
        push_frame(STATION_ID_RESET, CMD_ASK, {5{CHAR_ZERO}}, END_BYTE, 1'b0);
        push_scan(1'b1);
        queue_random_traffic(22);

        // Sweep station_id through its extremes, a random value and back to
        // the reset value; run one phase with no idling at all.
        wait_idle();
        reg_write(8'h00);
        calm = 1'b1;
        queue_random_traffic(22);

        wait_idle();
        calm = 1'b0;
        reg_write(8'hFF);
        queue_random_traffic(22);

        wait_idle();
        reg_write(8'($urandom_range(1, 254)));
        queue_random_traffic(22);

        wait_idle();
        reg_write(STATION_ID_RESET);
        queue_random_traffic(22);

        wait_idle();
        if (awaited_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", awaited_words.size()));
        if (error_count == 0)
            $display("tb_serial_frame_display_controller: PASS");
        else
            $display("tb_serial_frame_display_controller: FAIL");
        $finish;
    end

endmodule
